/* hdl/rwl_pkg.sv */
// Package for the read/write lock table: outcome codes, request and state types, defaults.
// Depends on nothing; used by every module of the lock table.
`timescale 1ns / 1ps
package rwl_pkg;
	localparam int MaxTrans = 64;
	localparam int NumItems = 1024;
	localparam int TidW = 6;
	localparam int ItemW = 10;

	typedef enum logic [2:0] {
		OUT_NEW = 3'd0,
		OUT_HELD = 3'd1,
		OUT_JOINED = 3'd2,
		OUT_UPGRADED = 3'd3,
		OUT_QUEUED = 3'd4
	} outcome_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN
	} state_t;

	// One request after classification in the front end.
	typedef struct packed {
		logic [TidW-1:0] tid;
		logic [ItemW-1:0] item;
		logic wr;
		logic tid_ok;
		logic item_ok;
	} req_t;
endpackage

/* hdl/rw_lock_table_acquire.sv */
// Top level of the read/write lock table with upgrade.
// Depends on rwl_pkg, rwl_front and rwl_back.
//
// Channel   Direction  Beat marks          Fields
// request   in         start & !busy       trans_id, item_id, want_write
// result    out        done (one cycle)    granted, outcome, owner_mask
//
// Each request passes from acceptance to its result strobe through a queue stage,
// then a read phase and a modify/write phase on the single-port entry memory; the
// back end takes no new request until the modify/write phase of the last is done.
// After reset a clearing sweep writes every entry; requests are still taken into
// the queue during the sweep until it holds two.
// The front queue holds two requests; busy rises only when it is full.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module rw_lock_table_acquire #(
	parameter int MAX_TRANSACTIONS = rwl_pkg::MaxTrans,
	parameter int NUM_ITEMS = rwl_pkg::NumItems
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [5:0] trans_id,
	input logic [9:0] item_id,
	input logic want_write,
	output logic done,
	output logic granted,
	output logic [2:0] outcome,
	output logic [63:0] owner_mask
);
	logic full, q_valid, q_pop, busy_back;
	rwl_pkg::req_t q_req;

	// Busy is the queue being full; the back end drains it on its own pace.
	assign busy = full;

	rwl_front #(.MAX_TRANSACTIONS(MAX_TRANSACTIONS), .NUM_ITEMS(NUM_ITEMS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .trans_id(trans_id),
		.item_id(item_id), .want_write(want_write), .full(full),
		.q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
	);

	rwl_back #(.NUM_ITEMS(NUM_ITEMS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
		.busy_back(busy_back), .done(done), .granted(granted), .outcome(outcome),
		.owner_mask(owner_mask)
	);

	// A pop happens only when the back end is free and something is queued.
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && $past(1'b1))) else $error("pop from empty queue");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> busy_back) else $error("back end not busy after pop");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_valid) else $error("full queue reads empty");
endmodule

/* hdl/rwl_front.sv */
// Front end of the lock table: takes request beats, range-checks them, queues them.
// Depends on rwl_pkg.
`timescale 1ns / 1ps
module rwl_front #(
	parameter int MAX_TRANSACTIONS = rwl_pkg::MaxTrans,
	parameter int NUM_ITEMS = rwl_pkg::NumItems
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [rwl_pkg::TidW-1:0] trans_id,
	input logic [rwl_pkg::ItemW-1:0] item_id,
	input logic want_write,
	output logic full,
	output logic q_valid,
	output rwl_pkg::req_t q_req,
	input logic q_pop
);
	// Two-entry queue.
	rwl_pkg::req_t slot_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	rwl_pkg::req_t cls;
	logic push;

	always_comb begin
		cls.tid = trans_id;
		cls.item = item_id;
		cls.wr = want_write;
		cls.tid_ok = ({26'd0, trans_id} < MAX_TRANSACTIONS);
		cls.item_ok = ({22'd0, item_id} < NUM_ITEMS);
	end

	assign push = in_valid && !full;
	assign full = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

/* hdl/rwl_back.sv */
// Back end of the lock table: entry memory, clearing sweep, read-modify-write.
// Depends on rwl_pkg.
`timescale 1ns / 1ps
module rwl_back #(
	parameter int NUM_ITEMS = rwl_pkg::NumItems
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input rwl_pkg::req_t q_req,
	output logic q_pop,
	output logic busy_back,
	output logic done,
	output logic granted,
	output logic [2:0] outcome,
	output logic [63:0] owner_mask
);
	localparam int AW = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
	localparam int EW = 1 + 1 + 3 * 64;

	logic [EW-1:0] mem [NUM_ITEMS];
	rwl_pkg::state_t st_q, st_d;
	logic [AW:0] clr_q;
	logic [EW-1:0] rd_s2;
	rwl_pkg::req_t req_s1;
	logic v_s1, v_s2;
	logic [AW-1:0] addr;
	logic we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic clr_we;

	// Phase one reads the entry; phase two modifies it, writing back in-range requests.
	assign addr = q_req.item[AW-1:0];
	assign q_pop = (st_q == rwl_pkg::ST_RUN) && q_valid && !v_s1;
	assign busy_back = (st_q != rwl_pkg::ST_RUN) || v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= rwl_pkg::ST_CLEAR;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		clr_we = 1'b0;
		case (st_q)
			rwl_pkg::ST_CLEAR: begin
				clr_we = 1'b1;
				if (clr_q == (AW+1)'(NUM_ITEMS - 1)) st_d = rwl_pkg::ST_RUN;
			end
			rwl_pkg::ST_RUN: st_d = rwl_pkg::ST_RUN;
			default: st_d = rwl_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			v_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			if (clr_we) clr_q <= clr_q + 1'b1;
			v_s1 <= q_pop;
			done <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) req_s1 <= q_req;
		if (q_pop) rd_s2 <= mem[addr];
		if (we) mem[waddr] <= wdata;
	end
	assign v_s2 = v_s1;

	logic e_v, e_wm;
	logic [63:0] e_own, e_wt, e_ww, me, n_own, n_wt, n_ww;
	logic n_v, n_wm, g;
	rwl_pkg::outcome_t oc;

	always_comb begin
		e_v = rd_s2[EW-1];
		e_wm = rd_s2[EW-2];
		e_own = rd_s2[191:128];
		e_wt = rd_s2[127:64];
		e_ww = rd_s2[63:0];
		me = 64'd1 << req_s1.tid;
		n_v = e_v; n_wm = e_wm; n_own = e_own; n_wt = e_wt; n_ww = e_ww;
		g = 1'b0;
		oc = rwl_pkg::OUT_QUEUED;
		if (!req_s1.item_ok) begin
			n_own = 64'd0;
		end else if (!req_s1.tid_ok) begin
			if (!e_v) n_own = 64'd0;
		end else if (!e_v) begin
			n_v = 1'b1; n_wm = req_s1.wr; n_own = me; g = 1'b1; oc = rwl_pkg::OUT_NEW;
		end else if ((e_own & me) != 64'd0) begin
			if (!e_wm && req_s1.wr) begin
				if ((e_own & (e_own - 64'd1)) == 64'd0) begin
					n_wm = 1'b1; g = 1'b1; oc = rwl_pkg::OUT_UPGRADED;
				end else begin
					n_wt = e_wt | me; n_ww = e_ww | me;
				end
			end else begin
				g = 1'b1; oc = rwl_pkg::OUT_HELD;
			end
		end else if (!e_wm && !req_s1.wr) begin
			n_own = e_own | me; g = 1'b1; oc = rwl_pkg::OUT_JOINED;
		end else begin
			n_wt = e_wt | me;
			if (req_s1.wr) n_ww = e_ww | me;
		end
	end

	assign we = clr_we || (v_s2 && req_s1.item_ok && req_s1.tid_ok);
	assign waddr = clr_we ? clr_q[AW-1:0] : req_s1.item[AW-1:0];
	assign wdata = clr_we ? '0 : {n_v, n_wm, n_own, n_wt, n_ww};

	always_ff @(posedge clk) begin
		if (v_s2) begin
			granted <= g;
			outcome <= oc;
			owner_mask <= n_own;
		end
	end

	// The result strobe always comes in the cycle after a modify/write phase.
	a_done: assert property (@(posedge clk) disable iff (!arst_n) v_s1 |=> done)
		else $error("result strobe missing");
	a_nopop: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == rwl_pkg::ST_CLEAR) |-> !q_pop) else $error("pop during clear");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n) q_pop |=> !q_pop)
		else $error("back end overlapped");
endmodule

/* tb/rw_lock_table_acquire_chk.sv */
// Checker for the lock table: watches request and result beats and predicts each result.
// Depends on rwl_pkg for the outcome codes.
`timescale 1ns / 1ps
module rw_lock_table_acquire_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [5:0] trans_id,
	input logic [9:0] item_id,
	input logic want_write,
	input logic done,
	input logic granted,
	input logic [2:0] outcome,
	input logic [63:0] owner_mask,
	output int errors,
	output int pending,
	output int n_results
);
	typedef struct packed {
		logic grant;
		rwl_pkg::outcome_t code;
		logic [63:0] owners;
	} lock_result_t;

	logic lk_valid [rwl_pkg::NumItems];
	logic lk_write [rwl_pkg::NumItems];
	logic [63:0] lk_owners [rwl_pkg::NumItems];
	logic [63:0] lk_waiters [rwl_pkg::NumItems];
	logic [63:0] lk_waiters_wr [rwl_pkg::NumItems];
	lock_result_t awaited [$];

	function automatic lock_result_t acquire_lock(logic [5:0] tid, logic [9:0] item, logic wr);
		lock_result_t r;
		logic [63:0] me;
		logic [63:0] own;
		me = 64'd1 << tid;
		own = lk_owners[item];
		r.grant = 1'b1;
		if (!lk_valid[item]) begin
			lk_valid[item] = 1'b1;
			lk_write[item] = wr;
			lk_owners[item] = me;
			r.code = rwl_pkg::OUT_NEW;
		end else if ((own & me) != 0) begin
			if (!lk_write[item] && wr) begin
				if ($onehot(own)) begin
					lk_write[item] = 1'b1;
					r.code = rwl_pkg::OUT_UPGRADED;
				end else begin
					lk_waiters[item] |= me;
					lk_waiters_wr[item] |= me;
					r.grant = 1'b0;
					r.code = rwl_pkg::OUT_QUEUED;
				end
			end else
				r.code = rwl_pkg::OUT_HELD;
		end else if (!lk_write[item] && !wr) begin
			lk_owners[item] = own | me;
			r.code = rwl_pkg::OUT_JOINED;
		end else begin
			lk_waiters[item] |= me;
			if (wr)
				lk_waiters_wr[item] |= me;
			r.grant = 1'b0;
			r.code = rwl_pkg::OUT_QUEUED;
		end
		r.owners = lk_owners[item];
		return r;
	endfunction

	// A result beat can never belong to a request taken at the same edge, so the
	// result is checked before the new request is predicted.
	always @(posedge clk) begin
		lock_result_t e;
		if (!arst_n) begin
			errors = 0;
			n_results = 0;
			awaited.delete();
			for (int i = 0; i < rwl_pkg::NumItems; i++) begin
				lk_valid[i] = 1'b0;
				lk_write[i] = 1'b0;
				lk_owners[i] = '0;
				lk_waiters[i] = '0;
				lk_waiters_wr[i] = '0;
			end
		end else begin
			if (done) begin
				n_results++;
				if (awaited.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat: granted %0d outcome %0d owners %h",
						$time, granted, outcome, owner_mask);
				end else begin
					e = awaited.pop_front();
					if (granted !== e.grant || outcome !== e.code || owner_mask !== e.owners) begin
						errors++;
						$display("%0t: mismatch: expected granted %0d outcome %0d owners %h, got %0d %0d %h",
							$time, e.grant, e.code, e.owners, granted, outcome, owner_mask);
					end
				end
			end
			if (start && !busy)
				awaited.push_back(acquire_lock(trans_id, item_id, want_write));
		end
		pending = awaited.size();
	end
endmodule

/* tb/rw_lock_table_acquire_tb.sv */
// Testbench top for the lock table: drives request beats and gives the verdict.
// Depends on rwl_pkg, rw_lock_table_acquire and rw_lock_table_acquire_chk.
`timescale 1ns / 1ps
module rw_lock_table_acquire_tb;
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [5:0] trans_id;
	logic [9:0] item_id;
	logic want_write;
	logic done;
	logic granted;
	logic [2:0] outcome;
	logic [63:0] owner_mask;
	int errors;
	int pending;
	int n_results;
	int n_sent;

	rw_lock_table_acquire u_top (.*);
	rw_lock_table_acquire_chk u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The block needs a clearing sweep and then serves one request at a time in its back
	// end; 200 us leaves a wide margin over the slowest correct run.
	initial begin
		#200000;
		$display("FAIL rw_lock_table_acquire");
		$finish;
	end

	// Present one request beat and hold it until the block takes it. The beat is
	// accepted at a rising edge with start high and busy low, so that edge is
	// checked before start is dropped or replaced at the next falling edge.
	task automatic send_request(input logic [5:0] tid, input logic [9:0] item,
			input logic wr, input bit may_idle);
		if (may_idle && $urandom_range(99) < 14) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		start <= 1'b1;
		trans_id <= tid;
		item_id <= item;
		want_write <= wr;
		do @(posedge clk); while (busy);
		n_sent++;
		@(negedge clk);
	endtask

	initial begin
		logic [9:0] hot;
		int grp;
		arst_n = 1'b0;
		start = 1'b0;
		trans_id = '0;
		item_id = '0;
		want_write = 1'b0;
		n_sent = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: new read, join, self-held, upgrade refused with two readers,
		// upgrade of a sole reader, writers queued with sticky write wishes, and the
		// extreme transaction and item numbers.
		send_request(6'd0, 10'd0, 1'b0, 0);
		send_request(6'd63, 10'd0, 1'b0, 0);
		send_request(6'd0, 10'd0, 1'b0, 0);
		send_request(6'd0, 10'd0, 1'b1, 0);
		send_request(6'd5, 10'd0, 1'b1, 0);
		send_request(6'd5, 10'd0, 1'b0, 0);
		send_request(6'd63, 10'd1023, 1'b0, 0);
		send_request(6'd63, 10'd1023, 1'b1, 0);
		send_request(6'd63, 10'd1023, 1'b1, 0);
		send_request(6'd1, 10'd1023, 1'b0, 0);
		send_request(6'd1, 10'd1023, 1'b1, 0);
		send_request(6'd42, 10'd512, 1'b1, 0);
		send_request(6'd42, 10'd512, 1'b0, 0);
		send_request(6'd21, 10'd512, 1'b0, 0);
		send_request(6'd0, 10'd341, 1'b0, 0);
		send_request(6'd0, 10'd341, 1'b1, 0);

		// Pause until every result is back before the random part.
		start <= 1'b0;
		while (pending != 0) @(negedge clk);

		// Random part: most requests hammer a small set of hot items from a few
		// transactions so joins, upgrades and queueing recur; the rest roam widely.
		for (int i = 0; i < 1150; i++) begin
			grp = $urandom_range(99);
			hot = 10'($urandom_range(15)) + 10'd100;
			if (grp < 70)
				send_request(6'($urandom_range(7)) << $urandom_range(3), hot,
					1'($urandom_range(2) == 0), i < 300 || i > 500);
			else
				send_request(6'($urandom), 10'($urandom), 1'($urandom),
					i < 300 || i > 500);
		end
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d request beats and checked %0d result beats on shared items.",
			n_sent, n_results);
		if (errors == 0 && pending == 0)
			$display("PASS rw_lock_table_acquire");
		else
			$display("FAIL rw_lock_table_acquire");
		$finish;
	end
endmodule

/* rw_lock_table_acquire.f */
hdl/rwl_pkg.sv
hdl/rwl_front.sv
hdl/rwl_back.sv
hdl/rw_lock_table_acquire.sv
tb/rw_lock_table_acquire_chk.sv
tb/rw_lock_table_acquire_tb.sv
